// ===== rtl/core/frlc_pkg.sv =====
// shared types, codes and constants of the flash record log controller
package frlc_pkg;

    localparam int SECTOR_COUNT_DEF     = 4;
    localparam int BLOCKS_IN_SECTOR_DEF = 16;
    localparam int QUEUE_DEPTH_DEF      = 4;

    localparam logic [31:0] COOKIE_ERASED = 32'hFFFF_FFFF;
    localparam logic [31:0] COOKIE_ZERO   = 32'h0000_0000;
    localparam logic [31:0] MAGIC_RESET   = 32'hDEAD_BEEF;
    localparam logic [15:0] START_RESET   = 16'h0000;

    localparam logic [1:0] FUNC_SAVE  = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_REPLY = 2'd2;

    localparam logic CFG_MAGIC = 1'b0;
    localparam logic CFG_START = 1'b1;

    typedef enum logic [2:0] {
        OP_READ_COOKIE = 3'd0,
        OP_ZERO_COOKIE = 3'd1,
        OP_ERASE       = 3'd2,
        OP_WRITE       = 3'd3,
        OP_READ_REC    = 3'd4,
        OP_NOT_FOUND   = 3'd5,
        OP_REJECT      = 3'd6
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] sector;
        logic [3:0]  block;
    } t_res;

    // up to three results, last_idx is the index of the final one
    typedef struct packed {
        logic [1:0]       last_idx;
        t_res [2:0]       res;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/core/frlc_front.sv =====
// front part: accepts requests, tracks the cursor and builds result groups
module frlc_front import frlc_pkg::*; #(
    parameter int SECTOR_COUNT     = SECTOR_COUNT_DEF,
    parameter int BLOCKS_IN_SECTOR = BLOCKS_IN_SECTOR_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_cookie,
    input  logic [31:0] i_magic,
    input  logic [15:0] i_start,
    input  t_q_status   i_q_status,
    output logic        o_stall,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam int SEC_W = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int BLK_W = (BLOCKS_IN_SECTOR > 1) ? $clog2(BLOCKS_IN_SECTOR) : 1;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTOR_COUNT - 1);
    localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCKS_IN_SECTOR - 1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SAVE,
        MODE_LOAD
    } t_mode;

    t_mode              r_mode,   n_mode;
    logic [SEC_W-1:0]   r_sector, n_sector;
    logic [BLK_W-1:0]   r_cursor, n_cursor;
    logic               accept;
    logic [1:0]         k;
    logic               cur_end;
    logic               sec_end;
    logic [SEC_W-1:0]   sec_inc;
    logic [BLK_W-1:0]   cur_inc;

    function automatic t_res mk(t_op op, logic [15:0] start, logic [SEC_W-1:0] sec,
                                logic [BLK_W-1:0] blk);
        t_res        r;
        logic [15:0] wide_blk;
        wide_blk = 16'(blk);
        r.op     = op;
        r.sector = start + 16'(sec);
        r.block  = wide_blk[3:0];
        return r;
    endfunction

    function automatic t_res blank(t_op op);
        t_res r;
        r.op     = op;
        r.sector = '0;
        r.block  = '0;
        return r;
    endfunction

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign o_push  = accept;
    assign cur_end = (r_cursor == BLK_LAST);
    assign sec_end = (r_sector == SEC_LAST);
    assign sec_inc = SEC_W'(r_sector + 1'b1);
    assign cur_inc = BLK_W'(r_cursor + 1'b1);

    always_comb begin
        n_mode            = r_mode;
        n_sector          = r_sector;
        n_cursor          = r_cursor;
        k                 = 2'd0;
        o_entry.last_idx  = 2'd0;
        o_entry.res       = '0;
        o_entry.res[0]    = blank(OP_REJECT);
        unique case (i_func)
            FUNC_SAVE, FUNC_LOAD: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode         = (i_func == FUNC_SAVE) ? MODE_SAVE : MODE_LOAD;
                    o_entry.res[0] = mk(OP_READ_COOKIE, i_start, r_sector, r_cursor);
                end
            end
            FUNC_REPLY: begin
                if (r_mode == MODE_SAVE) begin
                    if (i_cookie == COOKIE_ERASED) begin
                        o_entry.res[0] = mk(OP_WRITE, i_start, r_sector, r_cursor);
                        n_mode         = MODE_IDLE;
                    end else begin
                        if (i_cookie != COOKIE_ZERO) begin
                            o_entry.res[0] = mk(OP_ZERO_COOKIE, i_start, r_sector, r_cursor);
                            k              = 2'd1;
                        end
                        if (cur_end) begin
                            o_entry.res[k] = mk(OP_ERASE, i_start, r_sector, '0);
                            n_cursor       = '0;
                            if (sec_end) begin
                                n_sector              = '0;
                                n_mode                = MODE_IDLE;
                                o_entry.res[k + 2'd1] = mk(OP_WRITE, i_start, '0, '0);
                            end else begin
                                n_sector              = sec_inc;
                                o_entry.res[k + 2'd1] = mk(OP_READ_COOKIE, i_start,
                                                           sec_inc, '0);
                            end
                            o_entry.last_idx = k + 2'd1;
                        end else begin
                            n_cursor         = cur_inc;
                            o_entry.res[k]   = mk(OP_READ_COOKIE, i_start, r_sector, cur_inc);
                            o_entry.last_idx = k;
                        end
                    end
                end else if (r_mode == MODE_LOAD) begin
                    if (i_cookie == i_magic) begin
                        o_entry.res[0] = mk(OP_READ_REC, i_start, r_sector, r_cursor);
                        n_mode         = MODE_IDLE;
                    end else if (cur_end && sec_end) begin
                        n_cursor       = '0;
                        n_sector       = '0;
                        n_mode         = MODE_IDLE;
                        o_entry.res[0] = blank(OP_NOT_FOUND);
                    end else if (cur_end) begin
                        n_cursor       = '0;
                        n_sector       = sec_inc;
                        o_entry.res[0] = mk(OP_READ_COOKIE, i_start, sec_inc, '0);
                    end else begin
                        n_cursor       = cur_inc;
                        o_entry.res[0] = mk(OP_READ_COOKIE, i_start, r_sector, cur_inc);
                    end
                end
            end
            default: begin
                o_entry.res[0] = blank(OP_REJECT);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_sector <= '0;
            r_cursor <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_sector <= n_sector;
            r_cursor <= n_cursor;
        end
    end

endmodule

// ===== rtl/core/frlc_queue.sv =====
// short queue of result groups between front and back
module frlc_queue import frlc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_head         = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

endmodule

// ===== rtl/core/frlc_back.sv =====
// back part: sends the results of each group one at a time
module frlc_back import frlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [2:0]  o_op,
    output logic [15:0] o_sector_number,
    output logic [3:0]  o_block_index,
    output logic        o_last
);

    logic [1:0] r_sub;
    logic       r_valid;
    t_res       r_res;
    logic       r_last;
    logic       load;
    logic       is_last;
    t_res       cur;

    assign load    = !i_q_status.empty && (!r_valid || !i_stall);
    assign cur     = i_head.res[r_sub];
    assign is_last = (r_sub == i_head.last_idx);
    assign o_pop   = load && is_last;

    assign o_valid         = r_valid;
    assign o_op            = r_res.op;
    assign o_sector_number = r_res.sector;
    assign o_block_index   = r_res.block;
    assign o_last          = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sub   <= is_last ? 2'd0 : r_sub + 2'd1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= cur;
            r_last <= is_last;
        end
    end

endmodule

// ===== rtl/core/flash_record_log_controller_unit.sv =====
// top level of the flash record log controller
// a request's result group is written into the queue, then each result is registered in the back part's output register
// throughput: one request per cycle while the queue is not full; the output port sends one result per cycle
// while results are queued and i_out_stall is low, and sends the results of a request one after another
// reset clears the search state, queue and output valid and restores both config registers
module flash_record_log_controller_unit import frlc_pkg::*; #(
    parameter int SECTOR_COUNT     = SECTOR_COUNT_DEF,
    parameter int BLOCKS_IN_SECTOR = BLOCKS_IN_SECTOR_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_cookie,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_op,
    output logic [15:0] o_sector_number,
    output logic [3:0]  o_block_index,
    output logic        o_last
);

    logic [31:0] r_magic;
    logic [15:0] r_start;
    logic        push;
    logic        pop;
    t_entry      entry;
    t_entry      head;
    t_q_status   q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
            r_start <= START_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAGIC: r_magic <= i_cfg_data;
                CFG_START: r_start <= i_cfg_data[15:0];
                default:   r_magic <= r_magic;
            endcase
        end
    end

    frlc_front #(
        .SECTOR_COUNT     (SECTOR_COUNT),
        .BLOCKS_IN_SECTOR (BLOCKS_IN_SECTOR)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_func     (i_func),
        .i_cookie   (i_cookie),
        .i_magic    (r_magic),
        .i_start    (r_start),
        .i_q_status (q_status),
        .o_stall    (o_in_stall),
        .o_push     (push),
        .o_entry    (entry)
    );

    frlc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    frlc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .i_stall         (i_out_stall),
        .o_valid         (o_out_valid),
        .o_op            (o_op),
        .o_sector_number (o_sector_number),
        .o_block_index   (o_block_index),
        .o_last          (o_last)
    );

    a_blank_results_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_op == OP_REJECT || o_op == OP_NOT_FOUND)
        |-> o_last && o_sector_number == 16'd0 && o_block_index == 4'd0)
        else $error("reject or not found result malformed");

    a_erase_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_op == OP_ERASE |-> o_block_index == 4'd0 && !o_last)
        else $error("erase result malformed");

    a_zero_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_op == OP_ZERO_COOKIE |-> !o_last)
        else $error("zero cookie result ends its group");

    a_stall_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> o_in_stall && !q_status.empty)
        else $error("queue full without input stall");

endmodule

// ===== bench/testbench.sv =====
// testbench for the flash record log controller: directed and random requests checked by a model
import frlc_pkg::*;

typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_SAVE,
    SCAN_LOAD
} t_scan_mode;

typedef struct {
    t_op         op;
    logic [15:0] sector;
    logic [3:0]  block;
    logic        last;
} t_flash_op;

class flash_op_tracker;
    t_scan_mode  mode;
    int unsigned sector_idx;
    int unsigned block_pos;
    logic [31:0] magic;
    logic [15:0] start;
    t_flash_op   pending_ops[$];
    t_flash_op   batch[$];
    int          errors;
    int          requests;
    int          results;
    int          op_tally[8];

    function new();
        mode       = SCAN_IDLE;
        sector_idx = 0;
        block_pos  = 0;
        magic      = MAGIC_RESET;
        start      = START_RESET;
        errors     = 0;
        requests   = 0;
        results    = 0;
        foreach (op_tally[k]) op_tally[k] = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
        if (idx == CFG_MAGIC) begin
            magic = value;
        end else begin
            start = value[15:0];
        end
    endfunction

    function void add_at(t_op op, int unsigned sec, int unsigned blk);
        t_flash_op item;
        item.op     = op;
        item.sector = start + sec[15:0];
        item.block  = blk[3:0];
        item.last   = 1'b0;
        batch.push_back(item);
    endfunction

    function void add_blank(t_op op);
        t_flash_op item;
        item.op     = op;
        item.sector = '0;
        item.block  = '0;
        item.last   = 1'b0;
        batch.push_back(item);
    endfunction

    // accepted request: advance the cursor and queue the flash ops it causes
    function void note_request(logic [1:0] func, logic [31:0] cookie);
        batch.delete();
        requests++;
        if (func == FUNC_SAVE || func == FUNC_LOAD) begin
            if (mode != SCAN_IDLE) begin
                add_blank(OP_REJECT);
            end else begin
                mode = (func == FUNC_SAVE) ? SCAN_SAVE : SCAN_LOAD;
                add_at(OP_READ_COOKIE, sector_idx, block_pos);
            end
        end else if (func == FUNC_REPLY && mode == SCAN_SAVE) begin
            if (cookie == COOKIE_ERASED) begin
                add_at(OP_WRITE, sector_idx, block_pos);
                mode = SCAN_IDLE;
            end else begin
                if (cookie != COOKIE_ZERO) add_at(OP_ZERO_COOKIE, sector_idx, block_pos);
                block_pos++;
                if (block_pos >= BLOCKS_IN_SECTOR_DEF) begin
                    add_at(OP_ERASE, sector_idx, 0);
                    block_pos = 0;
                    sector_idx++;
                    if (sector_idx >= SECTOR_COUNT_DEF) begin
                        sector_idx = 0;
                        add_at(OP_WRITE, 0, 0);
                        mode = SCAN_IDLE;
                    end else begin
                        add_at(OP_READ_COOKIE, sector_idx, block_pos);
                    end
                end else begin
                    add_at(OP_READ_COOKIE, sector_idx, block_pos);
                end
            end
        end else if (func == FUNC_REPLY && mode == SCAN_LOAD) begin
            if (cookie == magic) begin
                add_at(OP_READ_REC, sector_idx, block_pos);
                mode = SCAN_IDLE;
            end else begin
                block_pos++;
                if (block_pos >= BLOCKS_IN_SECTOR_DEF) begin
                    block_pos = 0;
                    sector_idx++;
                end
                if (sector_idx >= SECTOR_COUNT_DEF) begin
                    sector_idx = 0;
                    add_blank(OP_NOT_FOUND);
                    mode = SCAN_IDLE;
                end else begin
                    add_at(OP_READ_COOKIE, sector_idx, block_pos);
                end
            end
        end else begin
            add_blank(OP_REJECT);
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) pending_ops.push_back(batch[k]);
    endfunction

    function void check_op(logic [2:0] op, logic [15:0] sector, logic [3:0] block,
                           logic last);
        t_flash_op want;
        results++;
        op_tally[op]++;
        if (pending_ops.size() == 0) begin
            $error("unexpected result op %0d sector_number %0d block_index %0d last %0d",
                   op, sector, block, last);
            errors++;
            return;
        end
        want = pending_ops.pop_front();
        if (op !== want.op) begin
            $error("op: expected %0d, actual %0d", want.op, op);
            errors++;
        end
        if (sector !== want.sector) begin
            $error("sector_number: expected %0d, actual %0d", want.sector, sector);
            errors++;
        end
        if (block !== want.block) begin
            $error("block_index: expected %0d, actual %0d", want.block, block);
            errors++;
        end
        if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = CFG_MAGIC;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_func      = FUNC_SAVE;
    logic [31:0] i_cookie    = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_op;
    logic [15:0] o_sector_number;
    logic [3:0]  o_block_index;
    logic        o_last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    flash_op_tracker tracker = new();

    flash_record_log_controller_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_cookie        (i_cookie),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_op            (o_op),
        .o_sector_number (o_sector_number),
        .o_block_index   (o_block_index),
        .o_last          (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            tracker.check_op(o_op, o_sector_number, o_block_index, o_last);
        end
    end

    task automatic issue_request(input logic [1:0] func, input logic [31:0] cookie);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_cookie   <= cookie;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_request(func, cookie);
    endtask

    task automatic program_regs(input logic [31:0] magic, input logic [15:0] start);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAGIC;
        i_cfg_data  <= magic;
        @(posedge i_clk);
        i_cfg_index <= CFG_START;
        i_cfg_data  <= {16'h0000, start};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_reg(CFG_MAGIC, magic);
        tracker.set_reg(CFG_START, {16'h0000, start});
    endtask

    function automatic logic [31:0] pick_cookie();
        int roll;
        roll = $urandom_range(0, 99);
        if (tracker.mode == SCAN_SAVE) begin
            if (roll < 5) return COOKIE_ERASED;
            if (roll < 45) return COOKIE_ZERO;
            if (roll < 55) return tracker.magic;
            return $urandom;
        end
        if (roll < 5) return tracker.magic;
        if (roll < 20) return COOKIE_ERASED;
        if (roll < 35) return COOKIE_ZERO;
        return $urandom;
    endfunction

    task automatic random_requests(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (tracker.mode == SCAN_IDLE) begin
                if (pick < 45) issue_request(FUNC_SAVE, $urandom);
                else if (pick < 88) issue_request(FUNC_LOAD, $urandom);
                else if (pick < 94) issue_request(FUNC_REPLY, $urandom);
                else issue_request(FUNC_UNUSED, $urandom);
            end else begin
                if (pick < 88) issue_request(FUNC_REPLY, pick_cookie());
                else if (pick < 92) issue_request(FUNC_SAVE, $urandom);
                else if (pick < 96) issue_request(FUNC_LOAD, $urandom);
                else issue_request(FUNC_UNUSED, $urandom);
            end
        end
    endtask

    // end any running search, then let every result come out
    task automatic settle();
        while (tracker.mode != SCAN_IDLE) begin
            issue_request(FUNC_REPLY,
                          (tracker.mode == SCAN_SAVE) ? COOKIE_ERASED : tracker.magic);
        end
        i_in_valid <= 1'b0;
        while (tracker.pending_ops.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        #200000;
        $display("run did not finish in time");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 22;
        recv_idle_pct = 77;
        program_regs(MAGIC_RESET, 16'hFFFE);

        // directed: idle reply, unused code, busy requests, every reply kind
        issue_request(FUNC_REPLY, COOKIE_ZERO);
        issue_request(FUNC_UNUSED, COOKIE_ERASED);
        issue_request(FUNC_SAVE, COOKIE_ZERO);
        issue_request(FUNC_LOAD, COOKIE_ERASED);
        issue_request(FUNC_SAVE, $urandom);
        issue_request(FUNC_REPLY, COOKIE_ZERO);
        issue_request(FUNC_REPLY, 32'h1234_5678);
        issue_request(FUNC_REPLY, COOKIE_ERASED);
        issue_request(FUNC_LOAD, COOKIE_ZERO);
        issue_request(FUNC_REPLY, COOKIE_ERASED);
        issue_request(FUNC_REPLY, COOKIE_ZERO);
        issue_request(FUNC_REPLY, MAGIC_RESET);
        // save that runs off the end of sector 0
        issue_request(FUNC_SAVE, COOKIE_ERASED);
        for (int b = 0; b < 12; b++) begin
            issue_request(FUNC_REPLY, b[0] ? COOKIE_ZERO : 32'h8000_0000 + b);
        end

        random_requests(50);
        settle();

        send_idle_pct = 77;
        recv_idle_pct = 22;
        program_regs(32'hFFFF_FFFF, 16'h0000);
        random_requests(55);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(32'h0000_0000, 16'hFFFF);
        random_requests(55);
        settle();

        program_regs($urandom, 16'($urandom_range(0, 65535)));
        random_requests(55);
        settle();

        $display("%0d requests under four register settings gave %0d results",
                 tracker.requests, tracker.results);
        $display("zero %0d, erase %0d, write %0d, read record %0d, not found %0d, rejected %0d",
                 tracker.op_tally[OP_ZERO_COOKIE], tracker.op_tally[OP_ERASE],
                 tracker.op_tally[OP_WRITE], tracker.op_tally[OP_READ_REC],
                 tracker.op_tally[OP_NOT_FOUND], tracker.op_tally[OP_REJECT]);
        if (tracker.errors == 0 && tracker.pending_ops.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
